[src/rfu_pkg.sv]
// ----------------------------------------------------------------------------
// rfu_pkg
// Shared types and constants for the ring FIFO with undo of the last push.
// ----------------------------------------------------------------------------
package rfu_pkg;

  // Default geometry
  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned DataWidthDefault = 8;

  // Width of the action code carried on tuser
  localparam int unsigned ActW = 2;

  // Action codes
  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;  // capture the input transaction
    logic exec;      // carry out the captured action
    logic cfg_wr;    // take a new capacity, empty the buffer
  } cmd_t;

endpackage

[src/ring_fifo_with_undo_push_core.sv]
// ----------------------------------------------------------------------------
// ring_fifo_with_undo_push_core
// Ring FIFO with a settable capacity, clear, and removal of the newest word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action per transaction: tuser holds the action code
//   (push, pop oldest, remove newest, clear) and tdata the word to push.
//   m_axis returns exactly one result per action: the popped word (zero
//   unless a pop succeeded), ok, fill level, full and empty after the action.
//   cfg carries the capacity; a write also empties the buffer. A capacity of
//   zero is taken as one, and one above DEPTH as DEPTH.
// Timing:
//   One action is in flight at a time. It is taken in the idle state, carried
//   out on the next cycle (single storage port, registered read), and its
//   result is shown the cycle after. A new action is not taken until the
//   result of the last one has been accepted.
// Reset:
//   The buffer is empty and the capacity is DEPTH. Storage is not cleared.
// Stall:
//   While m_axis_tready_i is low the result holds and s_axis_tready_o stays
//   low; the next action is taken once the result is accepted.
// ----------------------------------------------------------------------------
module ring_fifo_with_undo_push_core #(
  parameter int unsigned DEPTH      = rfu_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rfu_pkg::DataWidthDefault,
  localparam int unsigned LW        = $clog2(DEPTH + 1),
  localparam int unsigned IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned RES_W     = DATA_WIDTH + LW + 3,
  localparam int unsigned OUT_W     = ((RES_W + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // push_data
  input  logic [IN_W-1:0]          s_axis_tdata_i,
  // action
  input  logic [rfu_pkg::ActW-1:0] s_axis_tuser_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // pop_data, ok, fill_level, is_full, is_empty
  output logic [OUT_W-1:0]         m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // capacity
  input  logic [LW-1:0]            cfg_data_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o
);

  rfu_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] pop_data;
  logic                  ok;
  logic [LW-1:0]         fill_level;
  logic                  is_full;
  logic                  is_empty;
  logic [LW-1:0]         capacity;

  rfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  rfu_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (s_axis_tuser_i),
    .push_data_i  (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .cfg_data_i   (cfg_data_i),
    .pop_data_o   (pop_data),
    .ok_o         (ok),
    .fill_level_o (fill_level),
    .is_full_o    (is_full),
    .is_empty_o   (is_empty),
    .capacity_o   (capacity)
  );

  // Pack the result, first field lowest
  assign m_axis_tdata_o = OUT_W'({is_empty, is_full, fill_level, ok, pop_data});

  // Full and empty never coincide; the level never passes the capacity
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(is_full && is_empty))
    else $error("full and empty both set");

  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fill_level <= capacity) && (is_full == (fill_level == capacity)))
    else $error("fill level inconsistent with capacity");

  // One action in flight: no intake while a result is pending
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a result is pending");

  // An accepted action yields a result once it has passed the execute state
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.latch_in |-> ##2 m_axis_tvalid_o)
    else $error("result not presented after execute");

endmodule

[src/rfu_ctrl.sv]
// ----------------------------------------------------------------------------
// rfu_ctrl
// Sequencer: accept one transaction, execute it, present the result.
// ----------------------------------------------------------------------------
module rfu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rfu_pkg::cmd_t cmd_o
);

  rfu_pkg::state_e state_q, state_d;

  // Configuration takes precedence over a transaction in the idle state
  assign cfg_ready_o = (state_q == rfu_pkg::S_IDLE);
  assign in_ready_o  = (state_q == rfu_pkg::S_IDLE) && !cfg_valid_i;
  assign out_valid_o = (state_q == rfu_pkg::S_OUT);

  assign cmd_o.latch_in = in_valid_i && in_ready_o;
  assign cmd_o.exec     = (state_q == rfu_pkg::S_EXEC);
  assign cmd_o.cfg_wr   = cfg_valid_i && cfg_ready_o;

  // Advance the state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfu_pkg::S_IDLE: begin
        if (cmd_o.latch_in) state_d = rfu_pkg::S_EXEC;
      end
      rfu_pkg::S_EXEC: begin
        state_d = rfu_pkg::S_OUT;
      end
      rfu_pkg::S_OUT: begin
        if (out_ready_i) state_d = rfu_pkg::S_IDLE;
      end
      default: begin
        state_d = rfu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/rfu_datapath.sv]
// ----------------------------------------------------------------------------
// rfu_datapath
// Storage, ring indices, full flag, capacity register and result fields.
// ----------------------------------------------------------------------------
module rfu_datapath #(
  parameter int unsigned DEPTH      = rfu_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rfu_pkg::DataWidthDefault,
  localparam int unsigned IW        = $clog2(DEPTH),
  localparam int unsigned LW        = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rfu_pkg::cmd_t            cmd_i,
  input  logic [rfu_pkg::ActW-1:0] action_i,
  input  logic [DATA_WIDTH-1:0]    push_data_i,
  input  logic [LW-1:0]            cfg_data_i,
  output logic [DATA_WIDTH-1:0]    pop_data_o,
  output logic                     ok_o,
  output logic [LW-1:0]            fill_level_o,
  output logic                     is_full_o,
  output logic                     is_empty_o,
  output logic [LW-1:0]            capacity_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  rfu_pkg::action_e      act_q;
  logic [DATA_WIDTH-1:0] din_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [IW-1:0]         wr_idx_q, wr_idx_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic                  full_q, full_d;
  logic [LW-1:0]         cap_q, cap_d;
  logic                  ok_q, ok_d;
  logic                  pop_ok_q, pop_ok_d;

  logic                  empty;
  logic [IW-1:0]         wr_next, rd_next, wr_prev;
  logic [LW-1:0]         cfg_clamped;

  // Step an index forward, wrapping at the capacity in use
  function automatic logic [IW-1:0] step_fwd(logic [IW-1:0] idx, logic [LW-1:0] cap);
    logic [LW:0] n;
    n = (LW + 1)'(idx) + 1'b1;
    return (n >= (LW + 1)'(cap)) ? '0 : IW'(n);
  endfunction

  assign empty   = !full_q && (wr_idx_q == rd_idx_q);
  assign wr_next = step_fwd(wr_idx_q, cap_q);
  assign rd_next = step_fwd(rd_idx_q, cap_q);
  assign wr_prev = (wr_idx_q == '0) ? IW'(cap_q - 1'b1) : wr_idx_q - 1'b1;

  // Clamp a written capacity into one to DEPTH
  always_comb begin
    cfg_clamped = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_clamped = LW'(1);
    end else if (cfg_data_i > LW'(DEPTH)) begin
      cfg_clamped = LW'(DEPTH);
    end
  end

  // Execute the captured action, or take a new capacity and empty the buffer
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    full_d   = full_q;
    cap_d    = cap_q;
    ok_d     = ok_q;
    pop_ok_d = pop_ok_q;
    if (cmd_i.cfg_wr) begin
      cap_d    = cfg_clamped;
      wr_idx_d = '0;
      rd_idx_d = '0;
      full_d   = 1'b0;
    end else if (cmd_i.exec) begin
      ok_d     = 1'b0;
      pop_ok_d = 1'b0;
      case (act_q)
        rfu_pkg::ACT_PUSH: begin
          if (!full_q) begin
            wr_idx_d = wr_next;
            full_d   = (wr_next == rd_idx_q);
            ok_d     = 1'b1;
          end
        end
        rfu_pkg::ACT_POP: begin
          if (!empty) begin
            rd_idx_d = rd_next;
            full_d   = 1'b0;
            ok_d     = 1'b1;
            pop_ok_d = 1'b1;
          end
        end
        rfu_pkg::ACT_REMOVE: begin
          if (!empty) begin
            wr_idx_d = wr_prev;
            full_d   = 1'b0;
            ok_d     = 1'b1;
          end
        end
        default: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
          full_d   = 1'b0;
          ok_d     = 1'b1;
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      full_q   <= 1'b0;
      cap_q    <= LW'(DEPTH);
      ok_q     <= 1'b0;
      pop_ok_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      full_q   <= full_d;
      cap_q    <= cap_d;
      ok_q     <= ok_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= rfu_pkg::action_e'(action_i);
      din_q <= push_data_i;
    end
  end

  // Storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (act_q == rfu_pkg::ACT_PUSH) && !full_q) begin
      mem[wr_idx_q] <= din_q;
    end
    if (cmd_i.exec && (act_q == rfu_pkg::ACT_POP)) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  // Result fields
  always_comb begin
    if (full_q) begin
      fill_level_o = cap_q;
    end else if (wr_idx_q >= rd_idx_q) begin
      fill_level_o = LW'(wr_idx_q) - LW'(rd_idx_q);
    end else begin
      fill_level_o = cap_q - (LW'(rd_idx_q) - LW'(wr_idx_q));
    end
  end

  assign pop_data_o = pop_ok_q ? rd_data_q : '0;
  assign ok_o       = ok_q;
  assign is_full_o  = full_q;
  assign is_empty_o = empty;
  assign capacity_o = cap_q;

endmodule
